// ===== src/reliable_channel_sequencer_top_assert.svh =====
// Assertion macros for the reliable channel sequencer checker.
`ifndef RELIABLE_CHANNEL_SEQUENCER_TOP_ASSERT_SVH
`define RELIABLE_CHANNEL_SEQUENCER_TOP_ASSERT_SVH

// Checked on every clock edge outside reset.
`define RCS_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define RCS_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== src/rcs_pkg.sv =====
// Types and constants shared by the reliable channel sequencer files.
`timescale 1ns / 1ps
`default_nettype none
package rcs_pkg;

   localparam int SEQ_W       = 31;
   localparam int LEN_W       = 11;
   localparam int PKT_W       = 12;
   localparam int SUM_W       = 13;
   localparam int DROP_W      = 31;
   localparam int WORD_W      = 32;
   localparam int REQ_TDATA_W = 88;
   localparam int RSP_TDATA_W = 128;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int TAG_W       = 16;

   localparam logic OP_TRANSMIT = 1'b0;
   localparam logic OP_RECEIVE  = 1'b1;

   localparam logic CSR_IS_SERVER = 1'b0;
   localparam logic CSR_PORT_TAG  = 1'b1;

   localparam logic [SUM_W-1:0] HEADER_BYTES = 13'd8;
   localparam logic [SUM_W-1:0] TAG_BYTES    = 13'd2;

   typedef struct packed {
      logic [WORD_W-1:0] rx_word_two;
      logic [WORD_W-1:0] rx_word_one;
      logic [LEN_W-1:0]  unreliable_length;
      logic              pending_overflow;
      logic [LEN_W-1:0]  pending_length;
   } req_item_type;

   typedef struct packed {
      logic              rx_has_reliable;
      logic [DROP_W-1:0] dropped_count;
      logic [PKT_W-1:0]  packet_length;
      logic              include_unreliable;
      logic              pending_taken;
      logic [LEN_W-1:0]  reliable_bytes;
      logic              include_reliable;
      logic              include_port_tag;
      logic [WORD_W-1:0] tx_word_two;
      logic [WORD_W-1:0] tx_word_one;
      logic              accepted;
   } rsp_item_type;

endpackage
`default_nettype wire

// ===== src/rcs_engine.sv =====
// Sequence state and per-item header logic of the reliable channel sequencer.
`timescale 1ns / 1ps
`default_nettype none
module rcs_engine
   import rcs_pkg::*;
#(
   parameter int MAX_PACKET_BYTES = 1400
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         fire,
   input  wire logic         opcode,
   input  wire req_item_type item,
   input  wire logic         is_server,
   output rsp_item_type      result
);

   localparam logic [SUM_W-1:0] MaxBytes = SUM_W'(MAX_PACKET_BYTES);

   logic [SEQ_W-1:0] out_seq_ff, out_seq_in;
   logic [SEQ_W-1:0] inc_seq_ff, inc_seq_in;
   logic [SEQ_W-1:0] inc_ack_ff, inc_ack_in;
   logic             inc_rel_ack_ff, inc_rel_ack_in;
   logic             inc_rel_toggle_ff, inc_rel_toggle_in;
   logic             rel_toggle_ff, rel_toggle_in;
   logic [SEQ_W-1:0] last_sent_ff, last_sent_in;
   logic [LEN_W-1:0] rel_len_ff, rel_len_in;

   // transmit side
   logic             resend;
   logic             take;
   logic             send;
   logic [LEN_W-1:0] len_eff;
   logic [SEQ_W-1:0] seq_inc;
   logic [SUM_W-1:0] used;
   logic [SUM_W-1:0] total;
   logic             fit;

   // receive side
   logic [SEQ_W-1:0] rx_seq;
   logic             stale;

   assign resend  = (inc_ack_ff > last_sent_ff) && (inc_rel_ack_ff != rel_toggle_ff);
   assign take    = (rel_len_ff == '0) && (item.pending_length != '0);
   assign send    = resend | take;
   assign len_eff = take ? item.pending_length : rel_len_ff;
   assign seq_inc = out_seq_ff + SEQ_W'(1);
   assign used    = HEADER_BYTES + (is_server ? '0 : TAG_BYTES)
                    + (send ? SUM_W'(len_eff) : '0);
   assign total   = used + SUM_W'(item.unreliable_length);
   assign fit     = total <= MaxBytes;

   assign rx_seq = item.rx_word_one[SEQ_W-1:0];
   assign stale  = rx_seq <= inc_seq_ff;

   always_comb begin
      result            = '0;
      out_seq_in        = out_seq_ff;
      inc_seq_in        = inc_seq_ff;
      inc_ack_in        = inc_ack_ff;
      inc_rel_ack_in    = inc_rel_ack_ff;
      inc_rel_toggle_in = inc_rel_toggle_ff;
      rel_toggle_in     = rel_toggle_ff;
      last_sent_in      = last_sent_ff;
      rel_len_in        = rel_len_ff;
      if (opcode == OP_TRANSMIT) begin
         if (!item.pending_overflow) begin
            result.accepted           = 1'b1;
            result.tx_word_one        = {send, out_seq_ff};
            result.tx_word_two        = {inc_rel_toggle_ff, inc_seq_ff};
            result.include_port_tag   = ~is_server;
            result.include_reliable   = send;
            result.reliable_bytes     = send ? len_eff : '0;
            result.pending_taken      = take;
            result.include_unreliable = fit;
            result.packet_length      = fit ? total[PKT_W-1:0] : used[PKT_W-1:0];
            out_seq_in                = seq_inc;
            rel_len_in                = len_eff;
            rel_toggle_in             = rel_toggle_ff ^ take;
            if (send) begin
               last_sent_in = seq_inc;
            end
         end
      end else begin
         if (!stale) begin
            result.accepted        = 1'b1;
            result.dropped_count   = rx_seq - inc_seq_ff - DROP_W'(1);
            result.rx_has_reliable = item.rx_word_one[WORD_W-1];
            if (item.rx_word_two[WORD_W-1] == rel_toggle_ff) begin
               rel_len_in = '0;
            end
            inc_seq_in        = rx_seq;
            inc_ack_in        = item.rx_word_two[SEQ_W-1:0];
            inc_rel_ack_in    = item.rx_word_two[WORD_W-1];
            inc_rel_toggle_in = inc_rel_toggle_ff ^ item.rx_word_one[WORD_W-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_seq_ff        <= SEQ_W'(1);
         inc_seq_ff        <= '0;
         inc_ack_ff        <= '0;
         inc_rel_ack_ff    <= 1'b0;
         inc_rel_toggle_ff <= 1'b0;
         rel_toggle_ff     <= 1'b0;
         last_sent_ff      <= '0;
         rel_len_ff        <= '0;
      end else if (fire) begin
         out_seq_ff        <= out_seq_in;
         inc_seq_ff        <= inc_seq_in;
         inc_ack_ff        <= inc_ack_in;
         inc_rel_ack_ff    <= inc_rel_ack_in;
         inc_rel_toggle_ff <= inc_rel_toggle_in;
         rel_toggle_ff     <= rel_toggle_in;
         last_sent_ff      <= last_sent_in;
         rel_len_ff        <= rel_len_in;
      end
   end

endmodule
`default_nettype wire

// ===== src/reliable_channel_sequencer_top.sv =====
// Top level of the reliable channel sequencer: stream ports, CSR port, item pipeline.
// Stages: input register, then result register; an accepted item is held in the input
// register, and its result in the result register, where it waits on rsp until taken.
// Throughput: one item per cycle unless rsp stalls; state updates as an item enters the result
// register, and a new item enters while a result waits, as the result register frees when taken.
// Reset (synchronous, active high): empties both stages, outgoing sequence to 1, rest to 0.
`timescale 1ns / 1ps
`default_nettype none
module reliable_channel_sequencer_top
   import rcs_pkg::*;
#(
   parameter int MAX_PACKET_BYTES = 1400
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   // pending_length[10:0], pending_overflow[11], unreliable_length[22:12],
   // rx_word_one[54:23], rx_word_two[86:55], zero[87]
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,
   // opcode[0]
   input  wire logic                   req_tuser,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   // accepted[0], tx_word_one[32:1], tx_word_two[64:33], include_port_tag[65],
   // include_reliable[66], reliable_bytes[77:67], pending_taken[78],
   // include_unreliable[79], packet_length[91:80], dropped_count[122:92],
   // rx_has_reliable[123], zero[127:124]
   output logic [RSP_TDATA_W-1:0]      rsp_tdata,
   input  wire logic                   csr_psel,
   input  wire logic                   csr_penable,
   input  wire logic                   csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0]  csr_paddr,
   input  wire logic [CSR_DATA_W-1:0]  csr_pwdata,
   output logic [CSR_DATA_W-1:0]       csr_prdata,
   output logic                        csr_pready
);

   localparam int RspBits = $bits(rsp_item_type);

   logic             is_server_ff;
   logic [TAG_W-1:0] port_tag_ff;
   logic             csr_write;

   logic         in_valid_ff;
   logic         opcode_ff;
   req_item_type item_ff;
   logic         out_valid_ff;
   rsp_item_type rsp_item_ff;
   rsp_item_type result;
   logic         out_free;
   logic         fire;

   // configuration
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         is_server_ff <= 1'b0;
         port_tag_ff  <= '0;
      end else if (csr_write) begin
         case (csr_paddr[2])
            CSR_IS_SERVER: is_server_ff <= csr_pwdata[0];
            CSR_PORT_TAG:  port_tag_ff  <= csr_pwdata[TAG_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         CSR_IS_SERVER: csr_prdata = CSR_DATA_W'(is_server_ff);
         CSR_PORT_TAG:  csr_prdata = CSR_DATA_W'(port_tag_ff);
         default:       csr_prdata = '0;
      endcase
   end

   // item pipeline
   assign out_free   = ~out_valid_ff | rsp_tready;
   assign fire       = in_valid_ff & out_free;
   assign req_tready = ~in_valid_ff | out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (out_free) begin
            out_valid_ff <= in_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         item_ff   <= req_tdata[$bits(req_item_type)-1:0];
         opcode_ff <= req_tuser;
      end
      if (fire) begin
         rsp_item_ff <= result;
      end
   end

   rcs_engine #(
      .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
   ) u_rcs_engine (
      .clock    (clock),
      .reset    (reset),
      .fire     (fire),
      .opcode   (opcode_ff),
      .item     (item_ff),
      .is_server(is_server_ff),
      .result   (result)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W-RspBits){1'b0}}, rsp_item_ff};

endmodule
`default_nettype wire

// ===== src/rcs_checker.sv =====
// Port-level checker for the reliable channel sequencer, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "reliable_channel_sequencer_top_assert.svh"
module rcs_checker
   import rcs_pkg::*;
(
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   rsp_tvalid,
   input wire logic                   rsp_tready,
   input wire logic [RSP_TDATA_W-1:0] rsp_tdata
);

   `RCS_ASSERT(a_rsp_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "result changed while stalled")
   `RCS_ASSERT(a_reject_zero, rsp_tvalid && !rsp_tdata[0] |-> rsp_tdata == '0, "rejected item carries nonzero fields")
   `RCS_ASSERT(a_no_rel_no_bytes, rsp_tvalid && !rsp_tdata[66] |-> rsp_tdata[78:67] == '0, "reliable bytes or take without reliable part")
   `RCS_ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_tvalid, "result valid right after reset")

endmodule

bind reliable_channel_sequencer_top rcs_checker u_rcs_checker (.*);
`default_nettype wire
